>>> hdl/lsd_pkg.sv
package lsd_pkg;

    // register map
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_NOISE_SIGMA  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_W       = 11;
    localparam int SIGMA_W     = 16;
    localparam int OUT_PIX_W   = 8;
    localparam int IN_PIX_W    = 8;
    localparam int CHANNELS    = 3;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_WINDOW     = 5;
    localparam int DEF_PIXEL_BITS = 8;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [SIGMA_W-1:0] RST_NOISE_SIGMA  = 16'd100;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // accumulator control
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

endpackage

>>> hdl/lsd_ram.sv
module lsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 5120
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lsd_window_acc.sv
// Per-channel running sum and square sum of the window samples.
module lsd_window_acc #(
    parameter int PIXEL_BITS = 8,
    parameter int SUM_W      = 13,
    parameter int SQ_W       = 21
) (
    input  logic                                         clk,
    input  lsd_pkg::acc_ctrl_t                           ctrl,
    input  logic [lsd_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] pix,
    output logic [lsd_pkg::CHANNELS-1:0][SUM_W-1:0]      sum,
    output logic [lsd_pkg::CHANNELS-1:0][SQ_W-1:0]       sq_sum
);

    logic [lsd_pkg::CHANNELS-1:0][SUM_W-1:0] sum_reg;
    logic [lsd_pkg::CHANNELS-1:0][SQ_W-1:0]  sq_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lsd_pkg::CHANNELS; i++)
        begin
            if (ctrl.clear)
            begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
            else if (ctrl.add)
            begin
                sum_reg[i] <= sum_reg[i] + SUM_W'(pix[i]);
                sq_reg[i]  <= sq_reg[i] + SQ_W'(pix[i]) * SQ_W'(pix[i]);
            end
        end
    end

    assign sum    = sum_reg;
    assign sq_sum = sq_reg;

endmodule

>>> hdl/lsd_divider.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QB bits.
module lsd_divider #(
    parameter int NW = 40,
    parameter int QB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic          done,
    output logic [QB-1:0] quo
);

    localparam int TW = NW + QB;

    logic [NW-1:0]          rem_reg;
    logic [NW-1:0]          den_reg;
    logic [QB-1:0]          quo_reg;
    logic [$clog2(QB)-1:0]  step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [TW-1:0]          trial;
    logic                   fits;

    assign trial = TW'(den_reg) << step_reg;
    assign fits  = TW'(rem_reg) >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ($clog2(QB))'(QB - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg[step_reg] <= fits;
            if (fits)
            begin
                rem_reg <= NW'(TW'(rem_reg) - trial);
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hdl/local_statistics_denoise_unit.sv
// Channel  Signals                                          Direction
// in       in_valid/in_ready, req_type, red/green/blue_in   into block
// out      out_valid/out_ready, red/green/blue_out,
//          frame_last                                       out of block
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         into block
//
// An interior pixel's window is read one word a cycle from the line RAM,
// then the three channel divisions share one bit-serial divider.
// Edge pixels skip the window and pass the centre pixel through; items
// that give no result do not start the sequencer.
// rst_n clears counters and state registers asynchronously; the line RAM is not
// cleared. in_ready drops while an item is in work; a waiting result is held
// in the output register and the next item is still taken.
module local_statistics_denoise_unit #(
    parameter int MAX_WIDTH  = lsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lsd_pkg::DEF_MAX_HEIGHT,
    parameter int WINDOW     = lsd_pkg::DEF_WINDOW,
    parameter int PIXEL_BITS = lsd_pkg::DEF_PIXEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [lsd_pkg::IN_PIX_W-1:0]       red_in,
    input  logic [lsd_pkg::IN_PIX_W-1:0]       green_in,
    input  logic [lsd_pkg::IN_PIX_W-1:0]       blue_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lsd_pkg::OUT_PIX_W-1:0]      red_out,
    output logic [lsd_pkg::OUT_PIX_W-1:0]      green_out,
    output logic [lsd_pkg::OUT_PIX_W-1:0]      blue_out,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CH    = lsd_pkg::CHANNELS;
    localparam int HALF  = WINDOW / 2;
    localparam int AREA  = WINDOW * WINDOW;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SL_W  = $clog2(WINDOW);
    localparam int DEPTH = WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(WINDOW + 1);
    localparam longint PMAX = (longint'(1) << PIXEL_BITS) - 1;
    localparam int SUM_W = $clog2(longint'(AREA) * PMAX + 1);
    localparam int SQ_W  = $clog2(longint'(AREA) * PMAX * PMAX + 1);
    localparam int NW    = $clog2(longint'(65535) * AREA * AREA * PMAX
                                  + longint'(AREA) * AREA * PMAX * PMAX * PMAX + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CENTRE = 4'd1;
    localparam logic [3:0] S_CWAIT  = 4'd2;
    localparam logic [3:0] S_WREAD  = 4'd3;
    localparam logic [3:0] S_WLAST  = 4'd4;
    localparam logic [3:0] S_MA     = 4'd5;
    localparam logic [3:0] S_MB     = 4'd6;
    localparam logic [3:0] S_MC     = 4'd7;
    localparam logic [3:0] S_MD     = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    // configuration
    logic [WW-1:0]               used_w_reg;
    logic [HW-1:0]               used_h_reg;
    logic [lsd_pkg::SIGMA_W-1:0] sigma_reg;
    logic [CNT_W-1:0]            total;
    logic [CNT_W-1:0]            delay;

    // input and output position counters
    logic [WW-1:0]    in_col_reg;
    logic [HW-1:0]    in_row_reg;
    logic [SL_W-1:0]  in_slot_reg;
    logic [CNT_W-1:0] in_pos_reg;
    logic [WW-1:0]    out_col_reg;
    logic [HW-1:0]    out_row_reg;
    logic [SL_W-1:0]  out_slot_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    // pixel in work
    logic [WW-1:0]   k_col_reg;
    logic [SL_W-1:0] k_slot_reg;
    logic            k_last_reg;
    logic            k_int_reg;

    logic [3:0]      state_reg;
    logic [3:0]      state_next;
    logic [KW-1:0]   dr_reg;
    logic [KW-1:0]   dc_reg;
    logic [SL_W-1:0] w_slot_reg;
    logic [WW-1:0]   w_col_reg;
    logic            rd_pend_reg;
    logic [1:0]      ch_reg;

    logic [CH-1:0][PIXEL_BITS-1:0] centre_reg;
    logic [CH-1:0][PIXEL_BITS-1:0] res_reg;
    logic [NW-1:0] sq_reg;
    logic [NW-1:0] aq_reg;
    logic [NW-1:0] as_reg;
    logic [NW-1:0] var_reg;
    logic [NW-1:0] t_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] den_reg;

    logic                           out_valid_reg;
    logic [CH-1:0][PIXEL_BITS-1:0]  out_pix_reg;
    logic                           out_last_reg;

    logic in_xfer;
    logic cfg_xfer;
    logic frame_done;
    logic pix_restart;
    logic [WW-1:0]    cur_col;
    logic [HW-1:0]    cur_row;
    logic [SL_W-1:0]  cur_slot;
    logic [CNT_W-1:0] cur_pos;
    logic [CNT_W-1:0] cur_out_cnt;
    logic             emit;

    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CH*PIXEL_BITS-1:0] rdata;
    logic [CH-1:0][PIXEL_BITS-1:0] rpix;
    lsd_pkg::acc_ctrl_t acc_ctrl;
    logic [CH-1:0][SUM_W-1:0] sums;
    logic [CH-1:0][SQ_W-1:0]  sqs;
    logic [SUM_W-1:0]      s_sel;
    logic [SQ_W-1:0]       q_sel;
    logic [PIXEL_BITS-1:0] c_sel;
    logic div_start;
    logic div_done;
    logic [PIXEL_BITS-1:0] div_quo;
    logic [SL_W-1:0] start_slot;
    logic [WW-1:0]   start_col;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign total = CNT_W'(used_w_reg) * CNT_W'(used_h_reg);
    assign delay = CNT_W'(HALF) * CNT_W'(used_w_reg) + CNT_W'(HALF);

    // a pixel after a complete frame starts the next one
    assign frame_done  = (in_row_reg >= used_h_reg);
    assign pix_restart = frame_done;
    assign cur_col     = pix_restart ? '0 : in_col_reg;
    assign cur_row     = pix_restart ? '0 : in_row_reg;
    assign cur_slot    = pix_restart ? '0 : in_slot_reg;
    assign cur_pos     = pix_restart ? '0 : in_pos_reg;
    assign cur_out_cnt = pix_restart ? '0 : out_cnt_reg;

    always_comb
    begin
        emit = 1'b0;
        if (req_type == lsd_pkg::REQ_FLUSH)
        begin
            emit = frame_done && (out_cnt_reg < total);
        end
        else
        begin
            emit = (cur_pos >= delay) && (cur_out_cnt < total);
        end
    end

    // line RAM: rows kept modulo WINDOW, each row MAX_WIDTH words
    assign waddr = AW'(cur_slot) * AW'(MAX_WIDTH) + AW'(cur_col);
    assign raddr = (state_reg == S_WREAD)
                 ? AW'(w_slot_reg) * AW'(MAX_WIDTH) + AW'(w_col_reg)
                 : AW'(k_slot_reg) * AW'(MAX_WIDTH) + AW'(k_col_reg);

    lsd_ram #(
        .WIDTH (CH * PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (in_xfer && (req_type == lsd_pkg::REQ_PIXEL)),
        .waddr (waddr),
        .wdata ({PIXEL_BITS'(blue_in), PIXEL_BITS'(green_in), PIXEL_BITS'(red_in)}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rpix = rdata;

    assign acc_ctrl.clear = (state_reg == S_CWAIT);
    assign acc_ctrl.add   = rd_pend_reg;

    lsd_window_acc #(
        .PIXEL_BITS (PIXEL_BITS),
        .SUM_W      (SUM_W),
        .SQ_W       (SQ_W)
    ) u_acc (
        .clk    (clk),
        .ctrl   (acc_ctrl),
        .pix    (rpix),
        .sum    (sums),
        .sq_sum (sqs)
    );

    assign s_sel = sums[ch_reg];
    assign q_sel = sqs[ch_reg];
    assign c_sel = centre_reg[ch_reg];

    assign div_start = (state_reg == S_DSTART) && (den_reg != '0);

    lsd_divider #(
        .NW (NW),
        .QB (PIXEL_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // first window row and column around the pixel in work
    assign start_slot = (k_slot_reg >= SL_W'(HALF)) ? k_slot_reg - SL_W'(HALF)
                                                    : SL_W'(k_slot_reg + WINDOW - HALF);
    assign start_col  = k_col_reg - WW'(HALF);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_xfer && emit) state_next = S_CENTRE;
            S_CENTRE: state_next = S_CWAIT;
            S_CWAIT:  state_next = k_int_reg ? S_WREAD : S_OUT;
            S_WREAD:
            begin
                if ((dr_reg == KW'(WINDOW - 1)) && (dc_reg == KW'(WINDOW - 1)))
                begin
                    state_next = S_WLAST;
                end
            end
            S_WLAST:  state_next = S_MA;
            S_MA:     state_next = S_MB;
            S_MB:     state_next = S_MC;
            S_MC:     state_next = S_MD;
            S_MD:     state_next = S_DSTART;
            S_DSTART: state_next = (den_reg == '0) ? ((ch_reg == 2'(CH - 1)) ? S_OUT : S_MA)
                                                   : S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (ch_reg == 2'(CH - 1)) ? S_OUT : S_MA;
                end
            end
            S_OUT:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_w_reg    <= WW'(MAX_WIDTH);
            used_h_reg    <= HW'(MAX_HEIGHT);
            sigma_reg     <= lsd_pkg::RST_NOISE_SIGMA;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_pos_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            out_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            ch_reg        <= '0;
            dr_reg        <= '0;
            dc_reg        <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_WREAD);

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end

            // a valid register write restarts the frame
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    lsd_pkg::CFG_FRAME_WIDTH:
                    begin
                        if (32'(cfg_data[lsd_pkg::DIM_W-1:0]) > MAX_WIDTH)
                            used_w_reg <= WW'(MAX_WIDTH);
                        else if (cfg_data[lsd_pkg::DIM_W-1:0] == '0)
                            used_w_reg <= WW'(1);
                        else
                            used_w_reg <= WW'(cfg_data[lsd_pkg::DIM_W-1:0]);
                    end
                    lsd_pkg::CFG_FRAME_HEIGHT:
                    begin
                        if (32'(cfg_data[lsd_pkg::DIM_W-1:0]) > MAX_HEIGHT)
                            used_h_reg <= HW'(MAX_HEIGHT);
                        else if (cfg_data[lsd_pkg::DIM_W-1:0] == '0)
                            used_h_reg <= HW'(1);
                        else
                            used_h_reg <= HW'(cfg_data[lsd_pkg::DIM_W-1:0]);
                    end
                    lsd_pkg::CFG_NOISE_SIGMA:
                    begin
                        sigma_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
                if ((cfg_index == lsd_pkg::CFG_FRAME_WIDTH)
                    || (cfg_index == lsd_pkg::CFG_FRAME_HEIGHT)
                    || (cfg_index == lsd_pkg::CFG_NOISE_SIGMA))
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    in_pos_reg   <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    out_cnt_reg  <= '0;
                end
            end
            else if (in_xfer)
            begin
                if (req_type == lsd_pkg::REQ_PIXEL)
                begin
                    in_pos_reg <= cur_pos + 1'b1;
                    if (cur_col + 1'b1 >= used_w_reg)
                    begin
                        in_col_reg  <= '0;
                        in_row_reg  <= cur_row + 1'b1;
                        in_slot_reg <= (cur_slot == SL_W'(WINDOW - 1)) ? '0
                                                                       : cur_slot + 1'b1;
                    end
                    else
                    begin
                        in_col_reg  <= cur_col + 1'b1;
                        in_row_reg  <= cur_row;
                        in_slot_reg <= cur_slot;
                    end
                end
                if (pix_restart && (req_type == lsd_pkg::REQ_PIXEL))
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    out_cnt_reg  <= '0;
                end
                if (emit)
                begin
                    out_cnt_reg <= out_cnt_reg + 1'b1;
                    if (out_col_reg + 1'b1 >= used_w_reg)
                    begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + 1'b1;
                        out_slot_reg <= (out_slot_reg == SL_W'(WINDOW - 1)) ? '0
                                                                           : out_slot_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end

            // window walk
            if (state_reg == S_CWAIT)
            begin
                dr_reg <= '0;
                dc_reg <= '0;
            end
            else if (state_reg == S_WREAD)
            begin
                if (dc_reg == KW'(WINDOW - 1))
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + 1'b1;
                end
                else
                begin
                    dc_reg <= dc_reg + 1'b1;
                end
            end

            if (state_reg == S_CWAIT)
            begin
                ch_reg <= '0;
            end
            else if (((state_reg == S_DSTART) && (den_reg == '0))
                     || ((state_reg == S_DIV) && div_done))
            begin
                ch_reg <= ch_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            k_col_reg  <= out_col_reg;
            k_slot_reg <= out_slot_reg;
            k_last_reg <= (out_cnt_reg + 1'b1 == total);
            k_int_reg  <= (32'(out_row_reg) >= HALF)
                       && (32'(out_row_reg) + HALF < 32'(used_h_reg))
                       && (32'(out_col_reg) >= HALF)
                       && (32'(out_col_reg) + HALF < 32'(used_w_reg));
        end

        if (state_reg == S_CWAIT)
        begin
            centre_reg <= rpix;
            res_reg    <= rpix;
            w_slot_reg <= start_slot;
            w_col_reg  <= start_col;
        end
        else if (state_reg == S_WREAD)
        begin
            if (dc_reg == KW'(WINDOW - 1))
            begin
                w_col_reg  <= start_col;
                w_slot_reg <= (w_slot_reg == SL_W'(WINDOW - 1)) ? '0 : w_slot_reg + 1'b1;
            end
            else
            begin
                w_col_reg <= w_col_reg + 1'b1;
            end
        end

        // variance and weight terms, products registered in states S_MA to S_MD
        if (state_reg == S_MA)
        begin
            sq_reg <= NW'(s_sel) * NW'(s_sel);
            aq_reg <= NW'(q_sel) * NW'(AREA);
            as_reg <= NW'(s_sel) * NW'(AREA);
        end
        if (state_reg == S_MB)
        begin
            var_reg <= aq_reg - sq_reg;
        end
        if (state_reg == S_MC)
        begin
            t_reg <= NW'(sigma_reg) * as_reg;
        end
        if (state_reg == S_MD)
        begin
            num_reg <= t_reg + var_reg * NW'(c_sel);
            den_reg <= var_reg + NW'(sigma_reg) * NW'(AREA * AREA);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            res_reg[ch_reg] <= div_quo;
        end

        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            out_pix_reg  <= res_reg;
            out_last_reg <= k_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0][lsd_pkg::OUT_PIX_W-1:0];
    assign green_out  = out_pix_reg[1][lsd_pkg::OUT_PIX_W-1:0];
    assign blue_out   = out_pix_reg[2][lsd_pkg::OUT_PIX_W-1:0];
    assign frame_last = out_last_reg;

endmodule
